// ----- rtl/route_table_cam_assert.svh -----
// Assertion macros for the route table CAM.
// Used by route_table_cam.sv; expects clk and rst in scope.
`ifndef ROUTE_TABLE_CAM_ASSERT_SVH
`define ROUTE_TABLE_CAM_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rtc_pkg.sv -----
// Shared types and constants for the route table CAM.
// Used by rtc_cam.sv and route_table_cam.sv; no dependencies.
package rtc_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ADDR_BITS   = 32;
  localparam int FIELD_W     = 32;
  localparam int CNT_W       = 8;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_WRITE  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [FIELD_W-1:0] dest;
    logic [FIELD_W-1:0] nh;
    logic [CNT_W-1:0]   cnt;
  } req_t;

  typedef struct packed {
    logic hit;
    logic full;
  } cam_flags_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] nh;
    logic [CNT_W-1:0]     cnt;
  } route_t;

endpackage

// ----- rtl/rtc_cam.sv -----
// Key CAM with valid bits and the next-hop/count memory.
// Depends on rtc_pkg; match and free search are combinational on the request.
module rtc_cam (
  input  logic                clk,
  input  logic                rst,
  input  logic                commit,
  input  rtc_pkg::req_t       req,
  output rtc_pkg::cam_flags_t flags,
  output rtc_pkg::route_t     rd_route
);

  logic [rtc_pkg::ADDR_BITS-1:0]   entry_key [rtc_pkg::TABLE_DEPTH];
  logic [rtc_pkg::TABLE_DEPTH-1:0] entry_valid;
  logic [rtc_pkg::TABLE_DEPTH-1:0] entry_valid_next;
  rtc_pkg::route_t                 route_mem [rtc_pkg::TABLE_DEPTH];

  logic [rtc_pkg::ADDR_BITS-1:0]   key;
  logic [rtc_pkg::TABLE_DEPTH-1:0] match;
  logic [rtc_pkg::TABLE_DEPTH-1:0] free_oh;
  logic [rtc_pkg::TABLE_DEPTH-1:0] wr_oh;
  logic [rtc_pkg::IDX_W-1:0]       hit_idx;
  logic [rtc_pkg::IDX_W-1:0]       wr_idx;
  logic                            do_write;

  assign key = rtc_pkg::ADDR_BITS'(req.dest);

  always_comb begin
    for (int i = 0; i < rtc_pkg::TABLE_DEPTH; i++) begin
      match[i] = entry_valid[i] && (entry_key[i] == key);
    end
  end

  // Lowest invalid entry as a one-hot vector.
  assign free_oh = ~entry_valid & (entry_valid + rtc_pkg::TABLE_DEPTH'(1));

  assign flags.hit  = |match;
  assign flags.full = &entry_valid;
  assign wr_oh      = flags.hit ? match : free_oh;
  assign do_write   = commit && (req.op == rtc_pkg::OP_WRITE) && (flags.hit || !flags.full);

  // Both vectors are at most one-hot, so OR the indexes together.
  always_comb begin
    hit_idx = '0;
    wr_idx  = '0;
    for (int i = 0; i < rtc_pkg::TABLE_DEPTH; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | rtc_pkg::IDX_W'(i);
      end
      if (wr_oh[i]) begin
        wr_idx = wr_idx | rtc_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    entry_valid_next = entry_valid;
    if (commit) begin
      case (req.op)
        rtc_pkg::OP_WRITE: begin
          if (flags.hit || !flags.full) begin
            entry_valid_next = entry_valid | wr_oh;
          end
        end
        rtc_pkg::OP_REMOVE: entry_valid_next = entry_valid & ~match;
        rtc_pkg::OP_CLEAR:  entry_valid_next = '0;
        default:            entry_valid_next = entry_valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else begin
      entry_valid <= entry_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < rtc_pkg::TABLE_DEPTH; i++) begin
      if (do_write && wr_oh[i]) begin
        entry_key[i] <= key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      route_mem[wr_idx] <= '{nh: rtc_pkg::ADDR_BITS'(req.nh), cnt: req.cnt};
    end
    if (commit) begin
      rd_route <= route_mem[hit_idx];
    end
  end

endmodule

// ----- rtl/route_table_cam.sv -----
// Route table CAM: 64-entry associative table keyed by destination address.
// Requests and results are registered; one request per cycle unless out_ready stalls.
// The cycle is set by the parallel key compare over all register entries.
// Reset clears every valid bit and the pipeline; key and route storage is not cleared.
// Depends on rtc_pkg, rtc_cam and route_table_cam_assert.svh.
`include "route_table_cam_assert.svh"

module route_table_cam (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] dst,
  input  logic [31:0] gateway,
  input  logic [7:0]  hop_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] dest_echo,
  output logic        found,
  output logic [31:0] route_hop,
  output logic [7:0]  route_count,
  output logic        status
);

  localparam logic [rtc_pkg::ADDR_BITS-1:0] BCAST = '1;

  logic                s1_vld;
  rtc_pkg::req_t       s1_req;
  logic                s2_adv;
  logic                commit;
  rtc_pkg::cam_flags_t flags;
  rtc_pkg::route_t     rd_route;

  rtc_pkg::op_t        s2_op;
  logic                s2_lk_hit;
  logic                s2_lk_miss;
  logic                s1_clear;
  logic                s2_found_op;

  assign s2_adv   = !out_valid || out_ready;
  assign in_ready = !s1_vld || s2_adv;
  assign commit   = s1_vld && s2_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (in_ready) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req <= '{op: rtc_pkg::op_t'(op), dest: dst, nh: gateway, cnt: hop_count};
    end
  end

  rtc_cam u_cam (
    .clk      (clk),
    .rst      (rst),
    .commit   (commit),
    .req      (s1_req),
    .flags    (flags),
    .rd_route (rd_route)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      s2_op      <= s1_req.op;
      dest_echo  <= s1_req.dest;
      found      <= flags.hit && (s1_req.op == rtc_pkg::OP_LOOKUP ||
                                  s1_req.op == rtc_pkg::OP_REMOVE);
      status     <= (s1_req.op == rtc_pkg::OP_WRITE) && !flags.hit && flags.full;
      s2_lk_hit  <= (s1_req.op == rtc_pkg::OP_LOOKUP) && flags.hit;
      s2_lk_miss <= (s1_req.op == rtc_pkg::OP_LOOKUP) && !flags.hit;
    end
  end

  // Route memory data is registered alongside the result stage.
  always_comb begin
    if (s2_lk_hit) begin
      route_hop   = 32'(rd_route.nh);
      route_count = rd_route.cnt;
    end else if (s2_lk_miss) begin
      route_hop   = 32'(BCAST);
      route_count = '0;
    end else begin
      route_hop   = '0;
      route_count = '0;
    end
  end

  assign s1_clear    = commit && (s1_req.op == rtc_pkg::OP_CLEAR);
  assign s2_found_op = (s2_op == rtc_pkg::OP_LOOKUP) || (s2_op == rtc_pkg::OP_REMOVE);

  `RTC_ASSERT_NEXT(a_s1_hold, s1_vld && !s2_adv, s1_vld && $stable(s1_req), "request lost")
  `RTC_ASSERT_NOW(a_status_write, out_valid && status, s2_op == rtc_pkg::OP_WRITE, "bad status")
  `RTC_ASSERT_NOW(a_found_op, out_valid && found, s2_found_op, "found on wrong op")
  `RTC_ASSERT_NEXT(a_clear_empty, s1_clear, !flags.hit && !flags.full, "clear left entries")

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for route_table_cam: a directed table, then random request phases.
// Each accepted request is checked against a behavioral table model held here, or against a typed directed-row result.
// Depends on rtc_pkg and the route_table_cam RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int KEY_POOL    = 96;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_REQS = 1000;

  typedef struct packed {
    logic [31:0] dest;
    logic        found;
    logic [31:0] nh;
    logic [7:0]  cnt;
    logic        status;
  } route_result_t;

  typedef struct {
    rtc_pkg::op_t op;
    logic [31:0]  dest;
    logic [31:0]  hop;
    logic [7:0]   cnt;
    bit           typed;
    bit           found;
    logic [31:0]  res_hop;
    logic [7:0]   res_cnt;
    bit           status;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [31:0] dst;
  logic [31:0] gateway;
  logic [7:0]  hop_count;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] dest_echo;
  logic        found;
  logic [31:0] route_hop;
  logic [7:0]  route_count;
  logic        status;

  route_table_cam dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .dst(dst),
    .gateway(gateway),
    .hop_count(hop_count),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .dest_echo(dest_echo),
    .found(found),
    .route_hop(route_hop),
    .route_count(route_count),
    .status(status)
  );

  // Table model state
  bit          tbl_valid [rtc_pkg::TABLE_DEPTH];
  logic [31:0] tbl_key   [rtc_pkg::TABLE_DEPTH];
  logic [31:0] tbl_hop   [rtc_pkg::TABLE_DEPTH];
  logic [7:0]  tbl_cnt   [rtc_pkg::TABLE_DEPTH];

  route_result_t pending_results[$];
  logic [31:0]   key_pool [KEY_POOL];
  int            err_count;
  int            sent_count;
  int            stall_cycles;
  bit            quiet;

  directed_row_t directed_rows [0:21] = '{
    '{rtc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 8'h00, 1, 0, 32'hFFFF_FFFF, 8'h00, 0},
    '{rtc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1, 0, 32'hFFFF_FFFF, 8'h00, 0},
    '{rtc_pkg::OP_REMOVE, 32'h1234_5678, 32'h0000_0000, 8'h00, 1, 0, 32'h0000_0000, 8'h00, 0},
    '{rtc_pkg::OP_WRITE,  32'h0000_0000, 32'hFFFF_FFFF, 8'hFF, 1, 0, 32'h0000_0000, 8'h00, 0},
    '{rtc_pkg::OP_WRITE,  32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 1, 0, 32'h0000_0000, 8'h00, 0},
    '{rtc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 8'h00, 1, 1, 32'hFFFF_FFFF, 8'hFF, 0},
    '{rtc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 1, 1, 32'h0000_0000, 8'h00, 0},
    // overwrite in place
    '{rtc_pkg::OP_WRITE,  32'h0000_0000, 32'hA5A5_A5A5, 8'h5A, 1, 0, 32'h0000_0000, 8'h00, 0},
    '{rtc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h5A5A_5A5A, 8'hA5, 1, 1, 32'hA5A5_A5A5, 8'h5A, 0},
    '{rtc_pkg::OP_WRITE,  32'h8000_0001, 32'h7FFF_FFFE, 8'h80, 0, 0, 32'h0000_0000, 8'h00, 0},
    '{rtc_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 8'h00, 1, 1, 32'h0000_0000, 8'h00, 0},
    '{rtc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 8'h00, 1, 0, 32'hFFFF_FFFF, 8'h00, 0},
    // new key lands in the hole left by the remove
    '{rtc_pkg::OP_WRITE,  32'h1357_9BDF, 32'h2468_ACE0, 8'h7F, 0, 0, 32'h0000_0000, 8'h00, 0},
    '{rtc_pkg::OP_LOOKUP, 32'h8000_0001, 32'h0000_0000, 8'h00, 0, 0, 32'h0000_0000, 8'h00, 0},
    '{rtc_pkg::OP_LOOKUP, 32'h1357_9BDF, 32'h0000_0000, 8'h00, 0, 0, 32'h0000_0000, 8'h00, 0},
    '{rtc_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 8'h00, 1, 0, 32'h0000_0000, 8'h00, 0},
    '{rtc_pkg::OP_CLEAR,  32'hDEAD_BEEF, 32'hFFFF_FFFF, 8'hFF, 1, 0, 32'h0000_0000, 8'h00, 0},
    '{rtc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 1, 0, 32'hFFFF_FFFF, 8'h00, 0},
    '{rtc_pkg::OP_LOOKUP, 32'h1357_9BDF, 32'h0000_0000, 8'h00, 1, 0, 32'hFFFF_FFFF, 8'h00, 0},
    '{rtc_pkg::OP_WRITE,  32'h0000_0001, 32'h0000_0002, 8'h01, 0, 0, 32'h0000_0000, 8'h00, 0},
    '{rtc_pkg::OP_LOOKUP, 32'h0000_0001, 32'h0000_0000, 8'h00, 0, 0, 32'h0000_0000, 8'h00, 0},
    '{rtc_pkg::OP_REMOVE, 32'h0000_0001, 32'h0000_0000, 8'h00, 0, 0, 32'h0000_0000, 8'h00, 0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the table model and return the route result it yields.
  function automatic route_result_t apply_route_request(rtc_pkg::op_t req_op, logic [31:0] key,
                                                        logic [31:0] hop, logic [7:0] cnt);
    route_result_t res;
    int            hit;
    int            slot;
    int            i;
    res = '{dest: key, found: 1'b0, nh: 32'h0, cnt: 8'h0, status: 1'b0};
    hit = -1;
    slot = -1;
    for (i = rtc_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_key[i] == key) hit = i;
      if (!tbl_valid[i]) slot = i;
    end
    case (req_op)
      rtc_pkg::OP_LOOKUP: begin
        if (hit >= 0) begin
          res.found = 1'b1;
          res.nh = tbl_hop[hit];
          res.cnt = tbl_cnt[hit];
        end else begin
          res.nh = 32'hFFFF_FFFF;
        end
      end
      rtc_pkg::OP_WRITE: begin
        if (hit >= 0) slot = hit;
        if (slot >= 0) begin
          tbl_valid[slot] = 1'b1;
          tbl_key[slot] = key;
          tbl_hop[slot] = hop;
          tbl_cnt[slot] = cnt;
        end else begin
          res.status = 1'b1;
        end
      end
      rtc_pkg::OP_REMOVE: begin
        if (hit >= 0) begin
          tbl_valid[hit] = 1'b0;
          res.found = 1'b1;
        end
      end
      default: begin
        for (i = 0; i < rtc_pkg::TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    err_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(rtc_pkg::op_t req_op, logic [31:0] req_dest,
                              logic [31:0] req_hop, logic [7:0] req_cnt, bit typed = 0,
                              route_result_t typed_res = '0);
    route_result_t res;
    while (!quiet && $urandom_range(99) < 16) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    op = req_op;
    dst = req_dest;
    gateway = req_hop;
    hop_count = req_cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = apply_route_request(req_op, req_dest, req_hop, req_cnt);
    if (typed) res = typed_res;
    pending_results = {pending_results, res};
    sent_count++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(KEY_POOL - 1)];
    return $urandom;
  endfunction

  task automatic mixed_phase(int n);
    int           i;
    int           r;
    rtc_pkg::op_t req_op;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) req_op = rtc_pkg::OP_LOOKUP;
      else if (r < 72) req_op = rtc_pkg::OP_WRITE;
      else if (r < 96) req_op = rtc_pkg::OP_REMOVE;
      else req_op = rtc_pkg::OP_CLEAR;
      send_request(req_op, pick_key(), $urandom, 8'($urandom));
    end
  endtask

  // Fill the table past capacity, work on it while full, refill the holes, then look keys up.
  task automatic fill_table_phase();
    int order [KEY_POOL];
    int extra;
    int tmp;
    int i;
    int j;
    for (i = 0; i < KEY_POOL; i++) order[i] = i;
    for (i = KEY_POOL - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    extra = $urandom_range(6, 1);
    send_request(rtc_pkg::OP_CLEAR, $urandom, $urandom, 8'($urandom));
    for (i = 0; i < rtc_pkg::TABLE_DEPTH + extra; i++)
      send_request(rtc_pkg::OP_WRITE, key_pool[order[i]], $urandom, 8'($urandom));
    for (i = 0; i < 24; i++) begin
      j = order[$urandom_range(rtc_pkg::TABLE_DEPTH + extra - 1)];
      case ($urandom_range(3))
        0: send_request(rtc_pkg::OP_WRITE, key_pool[j], $urandom, 8'($urandom));
        3: send_request(rtc_pkg::OP_REMOVE, key_pool[j], $urandom, 8'($urandom));
        default: send_request(rtc_pkg::OP_LOOKUP, key_pool[j], $urandom, 8'($urandom));
      endcase
    end
    for (i = 0; i < 8; i++)
      send_request(rtc_pkg::OP_WRITE, key_pool[order[rtc_pkg::TABLE_DEPTH + extra + i]],
                   $urandom, 8'($urandom));
    for (i = 0; i < 12; i++)
      send_request(rtc_pkg::OP_LOOKUP, key_pool[order[$urandom_range(KEY_POOL - 1)]],
                   $urandom, 8'($urandom));
  endtask

  // Receiver: stall at random except during quiet stretches.
  always @(negedge clk) begin
    out_ready = quiet || ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    route_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", dest_echo, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (dest_echo !== want.dest) report_mismatch("dest_echo", dest_echo, want.dest);
        if (found !== want.found) report_mismatch("found", 32'(found), 32'(want.found));
        if (route_hop !== want.nh)
          report_mismatch("route_hop", route_hop, want.nh);
        if (route_count !== want.cnt)
          report_mismatch("route_count", 32'(route_count), 32'(want.cnt));
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int            i;
    int            j;
    int            phase;
    bit            dup;
    route_result_t typed_res;
    rst = 1'b1;
    in_valid = 1'b0;
    op = rtc_pkg::OP_LOOKUP;
    dst = 32'h0;
    gateway = 32'h0;
    hop_count = 8'h0;
    quiet = 1'b0;
    err_count = 0;
    sent_count = 0;
    for (i = 0; i < rtc_pkg::TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;

    // Distinct keys, with both address extremes in the pool
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (i = 2; i < KEY_POOL; i++) begin
      do begin
        key_pool[i] = $urandom;
        dup = 1'b0;
        for (j = 0; j < i; j++) if (key_pool[j] == key_pool[i]) dup = 1'b1;
      end while (dup);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[k]) begin
      typed_res = '{dest: directed_rows[k].dest, found: directed_rows[k].found,
                    nh: directed_rows[k].res_hop, cnt: directed_rows[k].res_cnt,
                    status: directed_rows[k].status};
      send_request(directed_rows[k].op, directed_rows[k].dest, directed_rows[k].hop,
                   directed_rows[k].cnt, directed_rows[k].typed, typed_res);
    end
    // Hold off until the table has answered everything
    drain_results();

    phase = 0;
    while (sent_count < RANDOM_REQS) begin
      quiet = (phase == 2) || ($urandom_range(4) == 0);
      if (phase % 3 == 1) fill_table_phase();
      else mixed_phase($urandom_range(60, 20));
      if ($urandom_range(3) == 0) drain_results();
      phase++;
    end
    quiet = 1'b0;

    drain_results();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
